>>> rtl/binomial_coefficient_row_unit_core_defines.svh
// assertion macros shared by the binomial row unit rtl
`ifndef BINOMIAL_COEFFICIENT_ROW_UNIT_CORE_DEFINES_SVH
`define BINOMIAL_COEFFICIENT_ROW_UNIT_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bcr_pkg.sv
// types and constants of the binomial row unit
`default_nettype none

package bcr_pkg;

    localparam int MAX_ROW   = 60;
    localparam int CNT_W     = 6;
    localparam int VALUE_W   = 63;
    localparam int ACC_W     = 64;
    localparam int MUL_STEPS = CNT_W;
    localparam int DIV_STEPS = ACC_W;
    localparam int MUL_CW    = $clog2(MUL_STEPS + 1);
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam logic CMD_COEF = 1'b0;
    localparam logic CMD_ROW  = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [CNT_W-1:0] n_value;
        logic [CNT_W-1:0] k_value;
    } item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [CNT_W-1:0]   entry_index;
        logic               last;
        logic               error;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/bcr_mul.sv
// shift-add multiplier: wide operand times a small count, one count bit per cycle
`default_nettype none

module bcr_mul (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bcr_pkg::ACC_W-1:0] a,
    input  wire logic [bcr_pkg::CNT_W-1:0] b,
    output logic      [bcr_pkg::ACC_W-1:0] product,
    output logic                           done
);

    logic [bcr_pkg::ACC_W-1:0]  a_reg;
    logic [bcr_pkg::CNT_W-1:0]  b_reg;
    logic [bcr_pkg::ACC_W-1:0]  p_reg;
    logic [bcr_pkg::MUL_CW-1:0] cnt_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= bcr_pkg::MUL_CW'(bcr_pkg::MUL_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == bcr_pkg::MUL_CW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            p_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= {a_reg[bcr_pkg::ACC_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[bcr_pkg::CNT_W-1:1]};
        end
    end

    assign product = p_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

>>> rtl/bcr_div.sv
// restoring divider: wide dividend by a small divisor, one quotient bit per cycle
`default_nettype none

module bcr_div (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [bcr_pkg::ACC_W-1:0] dividend,
    input  wire logic [bcr_pkg::CNT_W-1:0] divisor,
    output logic      [bcr_pkg::ACC_W-1:0] quotient,
    output logic                           done
);

    logic [bcr_pkg::ACC_W-1:0]  q_reg;
    logic [bcr_pkg::CNT_W-1:0]  rem_reg;
    logic [bcr_pkg::CNT_W-1:0]  d_reg;
    logic [bcr_pkg::DIV_CW-1:0] cnt_reg;
    logic                       done_reg;
    logic [bcr_pkg::CNT_W:0]    trial;
    logic                       fits;

    // remainder stays below the divisor, so only the narrow part is wide
    always_comb
    begin
        trial = {rem_reg, q_reg[bcr_pkg::ACC_W-1]};
        fits  = (trial >= {1'b0, d_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= bcr_pkg::DIV_CW'(bcr_pkg::DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == bcr_pkg::DIV_CW'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
            begin
                rem_reg <= bcr_pkg::CNT_W'(trial - {1'b0, d_reg});
            end
            else
            begin
                rem_reg <= trial[bcr_pkg::CNT_W-1:0];
            end
            q_reg <= {q_reg[bcr_pkg::ACC_W-2:0], fits};
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> rtl/binomial_coefficient_row_unit_core.sv
// binomial coefficient / pascal row unit: sequencer around serial multiply and divide
// each multiply-then-divide step runs the shift-add multiplier and then the
// bit-serial divider, with registered start pulses handing off between them.
// a coefficient request takes min(k, n-k) such steps before its result;
// a row request gives its first entry without any step, then one entry after
// each step, held while the result slot is stalled. one request is worked on at a time.
// reset (rst_n low, asynchronous) returns the sequencer to idle with no result pending.
`default_nettype none
`include "binomial_coefficient_row_unit_core_defines.svh"

module binomial_coefficient_row_unit_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire bcr_pkg::item_t   item_data,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output bcr_pkg::result_t      result_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_EMIT
    } state_t;

    state_t                     state_reg;
    logic                       mode_reg;
    logic                       err_reg;
    logic [bcr_pkg::CNT_W-1:0]  k_reg;
    logic [bcr_pkg::CNT_W-1:0]  a_reg;
    logic [bcr_pkg::CNT_W-1:0]  lim_reg;
    logic [bcr_pkg::CNT_W-1:0]  j_reg;
    logic [bcr_pkg::ACC_W-1:0]  acc_reg;
    logic                       mul_start_reg;
    logic                       div_start_reg;
    logic                       result_valid_reg;
    bcr_pkg::result_t           result_reg;

    logic                       mul_start_next;
    logic                       div_start_next;
    logic                       result_valid_next;

    logic [bcr_pkg::ACC_W-1:0]  product;
    logic                       mul_done;
    logic [bcr_pkg::ACC_W-1:0]  quotient;
    logic                       div_done;

    logic                       slot_free;
    logic                       coef_err;
    logic                       row_err;
    logic [bcr_pkg::CNT_W-1:0]  n_minus_k;
    logic [bcr_pkg::CNT_W-1:0]  kk;
    logic [bcr_pkg::CNT_W-1:0]  j_inc;
    logic                       emit_last;

    always_comb
    begin
        slot_free = !result_valid_reg || !result_stall;
        n_minus_k = item_data.n_value - item_data.k_value;
        coef_err  = (item_data.n_value == '0) || (item_data.k_value == '0)
                 || (item_data.k_value > item_data.n_value)
                 || (item_data.n_value > bcr_pkg::CNT_W'(bcr_pkg::MAX_ROW));
        row_err   = (item_data.n_value == '0)
                 || (item_data.n_value > bcr_pkg::CNT_W'(bcr_pkg::MAX_ROW));
        kk        = (n_minus_k < item_data.k_value) ? n_minus_k : item_data.k_value;
        j_inc     = j_reg + 1'b1;
        emit_last = err_reg || (mode_reg == bcr_pkg::CMD_COEF) || (j_reg == lim_reg);
    end

    // start pulses and result valid for the next cycle
    always_comb
    begin
        mul_start_next    = 1'b0;
        div_start_next    = 1'b0;
        result_valid_next = result_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                mul_start_next = item_valid && (item_data.cmd == bcr_pkg::CMD_COEF)
                              && !coef_err && (kk != '0);
            end
            S_MUL:
            begin
                div_start_next = mul_done;
            end
            S_DIV:
            begin
                mul_start_next = div_done && (mode_reg == bcr_pkg::CMD_COEF)
                              && (j_inc != lim_reg);
            end
            S_EMIT:
            begin
                // a held result stays, a free slot takes the new one
                result_valid_next = 1'b1;
                mul_start_next    = slot_free && !emit_last;
            end
            default:
            begin
                div_start_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mul_start_reg    <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= bcr_pkg::CMD_COEF;
            err_reg          <= 1'b0;
            k_reg            <= '0;
            a_reg            <= '0;
            lim_reg          <= '0;
            j_reg            <= '0;
            acc_reg          <= bcr_pkg::ACC_W'(1);
            result_reg       <= '0;
        end
        else
        begin
            mul_start_reg    <= mul_start_next;
            div_start_reg    <= div_start_next;
            result_valid_reg <= result_valid_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_valid)
                    begin
                        mode_reg <= item_data.cmd;
                        k_reg    <= item_data.k_value;
                        acc_reg  <= bcr_pkg::ACC_W'(1);
                        j_reg    <= '0;
                        if (item_data.cmd == bcr_pkg::CMD_ROW)
                        begin
                            err_reg   <= row_err;
                            a_reg     <= item_data.n_value - 1'b1;
                            lim_reg   <= item_data.n_value - 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            err_reg <= coef_err;
                            a_reg   <= item_data.n_value;
                            lim_reg <= kk;
                            if (coef_err || kk == '0)
                            begin
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                state_reg <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL:
                begin
                    if (mul_done)
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        acc_reg <= quotient;
                        j_reg   <= j_inc;
                        if (mode_reg == bcr_pkg::CMD_COEF && j_inc != lim_reg)
                        begin
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        result_reg.value       <= err_reg ? '0
                                                  : acc_reg[bcr_pkg::VALUE_W-1:0];
                        result_reg.entry_index <= (mode_reg == bcr_pkg::CMD_ROW)
                                                  ? j_reg : k_reg;
                        result_reg.last        <= emit_last;
                        result_reg.error       <= err_reg;
                        if (emit_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // next row entry / coefficient step: acc * (a - j) / (j + 1), exact
    bcr_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (acc_reg),
        .b       (a_reg - j_reg),
        .product (product),
        .done    (mul_done)
    );

    bcr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (product),
        .divisor  (j_inc),
        .quotient (quotient),
        .done     (div_done)
    );

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    `BCR_ASSERT_IMP(a_err_result_zero, result_valid && result_data.error,
                    result_data.value == '0 && result_data.last,
                    "error result must be zero and last")
    `BCR_ASSERT_IMP(a_mul_done_in_mul, mul_done, state_reg == S_MUL,
                    "multiplier finished outside multiply state")
    `BCR_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == S_DIV,
                    "divider finished outside divide state")
    `BCR_ASSERT_NXT(a_accept_leaves_idle, item_valid && !item_stall, state_reg != S_IDLE,
                    "accepted request did not start work")

endmodule

`default_nettype wire

>>> bench/binomial_coefficient_row_unit_core_tb.sv
// testbench for the binomial coefficient and pascal row unit
`timescale 1ns / 1ps

module binomial_coefficient_row_unit_core_tb;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int TAIL_CYCLES = 200;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int RANDOM_ITEMS = 131;

    class binomial_tally;
        bcr_pkg::result_t expected_entries[$];
        int mismatches;
        int entries_seen;

        function new();
            mismatches = 0;
            entries_seen = 0;
        endfunction

        // works out every entry that one accepted request should produce
        function void note_request(bcr_pkg::item_t req);
            bcr_pkg::result_t r;
            bit [63:0] acc;
            int nn;
            int kk;
            int span;
            int row_top;
            nn = int'(req.n_value);
            kk = int'(req.k_value);
            r.last = 1'b1;
            if (req.cmd == bcr_pkg::CMD_COEF)
            begin
                r.entry_index = req.k_value;
                if (nn < 1 || kk < 1 || kk > nn || nn > bcr_pkg::MAX_ROW)
                begin
                    r.value = '0;
                    r.error = 1'b1;
                end
                else
                begin
                    span = (nn - kk < kk) ? nn - kk : kk;
                    acc = 64'd1;
                    for (int j = 0; j < span; j++)
                        acc = acc * 64'(nn - j) / 64'(j + 1);
                    r.value = acc[bcr_pkg::VALUE_W-1:0];
                    r.error = 1'b0;
                end
                expected_entries.push_back(r);
            end
            else if (nn < 1 || nn > bcr_pkg::MAX_ROW)
            begin
                r.value = '0;
                r.entry_index = '0;
                r.error = 1'b1;
                expected_entries.push_back(r);
            end
            else
            begin
                row_top = nn - 1;
                acc = 64'd1;
                for (int i = 0; i <= row_top; i++)
                begin
                    r.value = acc[bcr_pkg::VALUE_W-1:0];
                    r.entry_index = bcr_pkg::CNT_W'(i);
                    r.last = (i == row_top);
                    r.error = 1'b0;
                    expected_entries.push_back(r);
                    if (i < row_top)
                        acc = acc * 64'(row_top - i) / 64'(i + 1);
                end
            end
        endfunction

        function void check_entry(bcr_pkg::result_t got);
            bcr_pkg::result_t want;
            entries_seen++;
            if (expected_entries.size() == 0)
            begin
                $error("unexpected result: value %0d index %0d last %0b error %0b",
                       got.value, got.entry_index, got.last, got.error);
                mismatches++;
                return;
            end
            want = expected_entries.pop_front();
            if (got.value !== want.value)
            begin
                $error("value: expected %0d, got %0d", want.value, got.value);
                mismatches++;
            end
            if (got.entry_index !== want.entry_index)
            begin
                $error("entry_index: expected %0d, got %0d", want.entry_index,
                       got.entry_index);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                mismatches++;
            end
            if (got.error !== want.error)
            begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    bcr_pkg::item_t   item_data = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    bcr_pkg::result_t result_data;

    binomial_tally tally = new();
    bit quiet = 1'b0;
    bit holdoff_done = 1'b0;
    int holdoff_left = 0;
    int cycles = 0;

    binomial_coefficient_row_unit_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("binomial_coefficient_row_unit_core regression: fail");
            $finish;
        end
    end

    // result side: check at each accepted result, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            tally.check_entry(result_data);
        if (!holdoff_done && tally.entries_seen >= 60)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            result_stall <= 1'b1;
        end
        else if (holdoff_left > 0)
        begin
            holdoff_left <= holdoff_left - 1;
            result_stall <= 1'b1;
        end
        else if (quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(99) < 20);
    end

    function automatic bcr_pkg::item_t make_request(logic cmd, int n, int k);
        bcr_pkg::item_t it;
        it.cmd = cmd;
        it.n_value = bcr_pkg::CNT_W'(n);
        it.k_value = bcr_pkg::CNT_W'(k);
        return it;
    endfunction

    task automatic send_request(input bcr_pkg::item_t req);
        item_valid <= 1'b1;
        item_data <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        tally.note_request(req);
        if (!quiet && $urandom_range(99) < 20)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain_expected();
        item_valid <= 1'b0;
        while (tally.expected_entries.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bcr_pkg::item_t req;
        int pick;
        int n;
        int big_left;
        big_left = 8;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both commands, every error case
        send_request(make_request(bcr_pkg::CMD_COEF, 1, 1));
        send_request(make_request(bcr_pkg::CMD_COEF, 60, 30));
        send_request(make_request(bcr_pkg::CMD_COEF, 60, 60));
        send_request(make_request(bcr_pkg::CMD_COEF, 60, 1));
        send_request(make_request(bcr_pkg::CMD_COEF, 59, 29));
        send_request(make_request(bcr_pkg::CMD_COEF, 10, 5));
        send_request(make_request(bcr_pkg::CMD_COEF, 0, 0));
        send_request(make_request(bcr_pkg::CMD_COEF, 0, 63));
        send_request(make_request(bcr_pkg::CMD_COEF, 5, 0));
        send_request(make_request(bcr_pkg::CMD_COEF, 5, 6));
        send_request(make_request(bcr_pkg::CMD_COEF, 61, 3));
        send_request(make_request(bcr_pkg::CMD_COEF, 63, 63));
        send_request(make_request(bcr_pkg::CMD_ROW, 1, 0));
        send_request(make_request(bcr_pkg::CMD_ROW, 2, 63));
        send_request(make_request(bcr_pkg::CMD_ROW, 5, 37));
        send_request(make_request(bcr_pkg::CMD_ROW, 60, 21));
        send_request(make_request(bcr_pkg::CMD_ROW, 0, 63));
        send_request(make_request(bcr_pkg::CMD_ROW, 61, 0));
        send_request(make_request(bcr_pkg::CMD_ROW, 63, 42));

        for (int idx = 0; idx < RANDOM_ITEMS; idx++)
        begin
            if (idx == 75)
                drain_expected();
            quiet = (idx >= 100 && idx < 130);
            pick = $urandom_range(99);
            if (pick < 90)
            begin
                // well-formed request, mostly small so the run stays short
                if (pick >= 85 && big_left > 0)
                begin
                    big_left--;
                    n = $urandom_range(40, bcr_pkg::MAX_ROW);
                end
                else
                    n = $urandom_range(1, 12);
                if (pick < 45 || (pick >= 85 && pick < 88))
                    req = make_request(bcr_pkg::CMD_COEF, n, $urandom_range(1, n));
                else
                    req = make_request(bcr_pkg::CMD_ROW, n, $urandom_range(0, 63));
            end
            else
                req = make_request(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                   $urandom_range(0, 63));
            send_request(req);
        end
        quiet = 1'b0;

        drain_expected();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tally.mismatches == 0 && tally.expected_entries.size() == 0)
            $display("binomial_coefficient_row_unit_core regression: pass");
        else
            $display("binomial_coefficient_row_unit_core regression: fail");
        $finish;
    end

endmodule
